/* src/dpd_pkg.sv */
// Shared types, character codes and helpers for the debug packet deframer.
package dpd_pkg;

    // Framing characters, 7-bit.
    localparam logic [6:0] CH_START = 7'h24;    // '$'
    localparam logic [6:0] CH_END   = 7'h23;    // '#'
    localparam logic [6:0] CH_SEQ   = 7'h3a;    // ':'

    localparam logic [9:0] BYTE_COUNT_MAX = 10'h3ff;

    // Command queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_BODY,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic       out_kind;
        logic [6:0] out_char;
        logic       out_good;
        logic       out_has_seq;
        logic [6:0] out_seq_first;
        logic [6:0] out_seq_second;
        logic       out_last;
    } out_t;

    // One request's worth of results: up to three characters, then an optional verdict.
    typedef struct packed {
        logic [1:0]      nchars;
        logic [2:0][6:0] chars;
        logic            verdict;
        logic            good;
        logic            has_seq;
        logic [6:0]      seq_first;
        logic [6:0]      seq_second;
    } cmd_t;

    // Returns {invalid, value}.
    function automatic logic [4:0] hex_decode(logic [6:0] c);
        logic [4:0] r;
        begin
            r = 5'h10;
            if (c >= 7'h30 && c <= 7'h39)
            begin
                r = {1'b0, 4'(c - 7'h30)};
            end
            else if (c >= 7'h61 && c <= 7'h66)
            begin
                r = {1'b0, 4'(c - 7'h57)};
            end
            else if (c >= 7'h41 && c <= 7'h46)
            begin
                r = {1'b0, 4'(c - 7'h37)};
            end
            return r;
        end
    endfunction

endpackage

/* src/dpd_front.sv */
// Front part: accepts bytes, tracks packet framing and checksum, and builds result commands.
module dpd_front #(
    parameter int MAX_LEN = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    input  dpd_pkg::in_t  byte_data,
    input  logic          q_full,
    output logic          byte_stall,
    output logic          push,
    output dpd_pkg::cmd_t push_cmd
);

    localparam logic [9:0] MAX_LEN_W = 10'(MAX_LEN);

    dpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      sum_reg, sum_next;
    logic [3:0]      rhn_reg, rhn_next;
    logic [7:0]      rsum_reg, rsum_next;
    logic [2:0][6:0] hold_reg, hold_next;
    logic [1:0]      hc_reg, hc_next;
    logic            seq_reg, seq_next;
    logic            bad_reg, bad_next;
    logic [9:0]      bc_reg, bc_next;

    logic            accept;
    logic [6:0]      b;
    logic [4:0]      hex;
    logic            one_char;
    logic [1:0]      nch;

    assign accept     = byte_valid && !q_full;
    assign byte_stall = q_full;
    assign b          = byte_data.in_byte[6:0];
    assign hex        = dpd_pkg::hex_decode(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dpd_pkg::PH_HUNT;
            sum_reg   <= '0;
            rhn_reg   <= '0;
            rsum_reg  <= '0;
            hold_reg  <= '0;
            hc_reg    <= '0;
            seq_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            bc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            rhn_reg   <= rhn_next;
            rsum_reg  <= rsum_next;
            hold_reg  <= hold_next;
            hc_reg    <= hc_next;
            seq_reg   <= seq_next;
            bad_reg   <= bad_next;
            bc_reg    <= bc_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        rhn_next   = rhn_reg;
        rsum_next  = rsum_reg;
        hold_next  = hold_reg;
        hc_next    = hc_reg;
        seq_next   = seq_reg;
        bad_next   = bad_reg;
        bc_next    = bc_reg;
        one_char   = 1'b0;
        nch        = 2'd0;
        push       = 1'b0;
        push_cmd   = '0;

        if (accept)
        begin
            if (bc_reg != dpd_pkg::BYTE_COUNT_MAX)
            begin
                bc_next = bc_reg + 10'd1;
            end
            if (bc_next > MAX_LEN_W)
            begin
                bad_next = 1'b1;
            end

            unique case (phase_reg)
                dpd_pkg::PH_HUNT:
                begin
                    if (b == dpd_pkg::CH_START)
                    begin
                        phase_next = dpd_pkg::PH_BODY;
                    end
                end
                dpd_pkg::PH_BODY:
                begin
                    if (b == dpd_pkg::CH_END)
                    begin
                        phase_next = dpd_pkg::PH_HEX_HI;
                    end
                    else
                    begin
                        sum_next = sum_reg + {1'b0, b};
                        if (hc_reg != 2'd3)
                        begin
                            hold_next[hc_reg] = b;
                            hc_next = hc_reg + 2'd1;
                            // The third held character decides whether a sequence id leads.
                            if (hc_reg == 2'd2)
                            begin
                                if (b == dpd_pkg::CH_SEQ)
                                begin
                                    seq_next = 1'b1;
                                end
                                else
                                begin
                                    nch = 2'd3;
                                end
                            end
                        end
                        else
                        begin
                            one_char = 1'b1;
                            nch = 2'd1;
                        end
                    end
                end
                dpd_pkg::PH_HEX_HI:
                begin
                    if (hex[4])
                    begin
                        bad_next = 1'b1;
                    end
                    rhn_next   = hex[3:0];
                    phase_next = dpd_pkg::PH_HEX_LO;
                end
                dpd_pkg::PH_HEX_LO:
                begin
                    if (hex[4])
                    begin
                        bad_next = 1'b1;
                    end
                    rsum_next  = {rhn_reg, hex[3:0]};
                    phase_next = dpd_pkg::PH_DONE;
                end
                dpd_pkg::PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            push_cmd.chars = hold_next;
            if (one_char)
            begin
                push_cmd.chars[0] = b;
            end

            if (byte_data.in_last)
            begin
                // Characters still held back are flushed ahead of the verdict.
                if (hc_next != 2'd3)
                begin
                    nch = hc_next;
                end
                push_cmd.verdict = 1'b1;
                push_cmd.good    = (phase_next == dpd_pkg::PH_DONE) && !bad_next &&
                                   (rsum_next == sum_next);
                push_cmd.has_seq = seq_next;
                if (seq_next)
                begin
                    push_cmd.seq_first  = hold_next[0];
                    push_cmd.seq_second = hold_next[1];
                end

                phase_next = dpd_pkg::PH_HUNT;
                sum_next   = '0;
                rhn_next   = '0;
                rsum_next  = '0;
                hold_next  = '0;
                hc_next    = '0;
                seq_next   = 1'b0;
                bad_next   = 1'b0;
                bc_next    = '0;
            end

            push_cmd.nchars = nch;
            push = (nch != 2'd0) || byte_data.in_last;
        end
    end

endmodule

/* src/dpd_queue.sv */
// Short command queue that decouples the front part from the back part.
module dpd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dpd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output dpd_pkg::cmd_t head
);

    dpd_pkg::cmd_t                  mem_reg [dpd_pkg::QDEPTH];
    logic [dpd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dpd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dpd_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full  = (count_reg == dpd_pkg::QCNT_W'(dpd_pkg::QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + dpd_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + dpd_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + dpd_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - dpd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/dpd_back.sv */
// Back part: expands each command into result items in an output register, one per cycle unless stalled.
module dpd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  dpd_pkg::cmd_t q_head,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_stall,
    output dpd_pkg::out_t result_data
);

    dpd_pkg::cmd_t cmd_reg, cmd_next;
    logic          cmd_valid_reg, cmd_valid_next;
    logic [1:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    dpd_pkg::out_t out_reg, out_next;

    logic [2:0]    total;
    logic          is_last;
    logic          load;
    dpd_pkg::out_t cur;

    assign total        = {1'b0, cmd_reg.nchars} + {2'b00, cmd_reg.verdict};
    assign is_last      = (({1'b0, idx_reg} + 3'd1) == total);
    assign load         = !out_valid_reg || !result_stall;
    assign pop          = q_valid && (!cmd_valid_reg || (load && is_last));
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_comb
    begin
        cur = '0;
        if ({1'b0, idx_reg} < {1'b0, cmd_reg.nchars})
        begin
            case (idx_reg)
                2'd0:    cur.out_char = cmd_reg.chars[0];
                2'd1:    cur.out_char = cmd_reg.chars[1];
                2'd2:    cur.out_char = cmd_reg.chars[2];
                default: cur.out_char = '0;
            endcase
        end
        else
        begin
            cur.out_kind       = 1'b1;
            cur.out_good       = cmd_reg.good;
            cur.out_has_seq    = cmd_reg.has_seq;
            cur.out_seq_first  = cmd_reg.seq_first;
            cur.out_seq_second = cmd_reg.seq_second;
        end
        cur.out_last = is_last;
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (load)
        begin
            out_valid_next = cmd_valid_reg;
            out_next       = cur;
            if (cmd_valid_reg)
            begin
                if (is_last)
                begin
                    cmd_valid_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end

        // The next command is taken in as the current one hands out its final result.
        if (pop)
        begin
            cmd_next       = q_head;
            cmd_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

endmodule

/* src/debug_packet_deframer.sv */
// Top level of the debug packet deframer: front part, command queue and back part.
//
// Usage: datagram bytes enter on the byte channel (byte_valid, byte_stall, byte_data),
// with in_last set on the final byte of each datagram. Results leave on the result
// channel (result_valid, result_stall, result_data): payload characters with the
// framing, sequence id and checksum stripped, and one verdict per datagram.
// Each request is accepted when valid is high and stall is low at a rising edge.
// A byte's first result passes the command queue, the command register and the result
// register. Throughput: one byte per cycle unless the queue is full, one result per
// cycle unless the receiver stalls; a byte that releases the held-back characters plus a
// verdict gives up to four results, which leave on consecutive cycles unless stalled. A
// four-entry command queue absorbs such bursts; byte_stall rises only when it is full.
// When the receiver stalls, the result register holds its value, the back part waits
// and the queue fills; the front part keeps taking bytes until then.
// Reset (rst_n low) returns the parser to hunting for the start character and
// empties the queue and the output register.
module debug_packet_deframer #(
    parameter int MAX_LEN = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  dpd_pkg::in_t  byte_data,
    output logic          result_valid,
    input  logic          result_stall,
    output dpd_pkg::out_t result_data
);

    logic          push;
    dpd_pkg::cmd_t push_cmd;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    dpd_pkg::cmd_t q_head;

    dpd_front #(
        .MAX_LEN(MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .byte_stall (byte_stall),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    dpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the debug packet deframer: random datagrams against a parser model.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_LEN = 512;

    typedef enum int {
        CLEAN,
        BAD_SUM,
        BAD_DIGIT
    } flaw_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           byte_valid = 1'b0;
    logic           byte_stall;
    dpd_pkg::in_t   byte_data = '0;
    logic           result_valid;
    logic           result_stall = 1'b0;
    dpd_pkg::out_t  result_data;

    debug_packet_deframer #(
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_data(byte_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data)
    );

    always #1 clk = ~clk;

    dpd_pkg::in_t   tx_bytes[$];
    logic [7:0]     frame_bytes[$];
    dpd_pkg::out_t  predicted_out[$];
    int             err_count = 0;
    bit             byte_took = 1'b0;
    bit             calm = 1'b0;
    int             gap_left = 0;
    int             stall_left = 0;
    int             hold_left = 0;
    int             rx_cycles = 0;

    // Parser state mirrored from the block.
    dpd_pkg::phase_t ph = dpd_pkg::PH_HUNT;
    logic [7:0]      run_sum = '0;
    logic [3:0]      hi_nib = '0;
    logic [7:0]      rx_sum = '0;
    logic [6:0]      held[3] = '{default: '0};
    int              held_n = 0;
    bit              seq_seen = 1'b0;
    bit              frame_bad = 1'b0;
    int              nbytes = 0;

    function automatic int hex_nibble(logic [6:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic dpd_pkg::out_t char_result(logic [6:0] c);
        dpd_pkg::out_t r;
        r = '0;
        r.out_char = c;
        return r;
    endfunction

    // Works out the results caused by one accepted request.
    task automatic parse_byte(dpd_pkg::in_t it);
        logic [6:0]    c;
        int            v;
        int            n;
        dpd_pkg::out_t res[4];
        dpd_pkg::out_t r;
        c = it.in_byte[6:0];
        n = 0;
        if (nbytes < 1023)
        begin
            nbytes++;
        end
        if (nbytes > MAX_LEN)
        begin
            frame_bad = 1'b1;
        end
        case (ph)
            dpd_pkg::PH_HUNT:
            begin
                if (c == dpd_pkg::CH_START)
                begin
                    ph = dpd_pkg::PH_BODY;
                end
            end
            dpd_pkg::PH_BODY:
            begin
                if (c == dpd_pkg::CH_END)
                begin
                    ph = dpd_pkg::PH_HEX_HI;
                end
                else
                begin
                    run_sum = run_sum + {1'b0, c};
                    if (held_n < 3)
                    begin
                        held[held_n] = c;
                        held_n++;
                        if (held_n == 3)
                        begin
                            if (held[2] == dpd_pkg::CH_SEQ)
                            begin
                                seq_seen = 1'b1;
                            end
                            else
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    res[n] = char_result(held[i]);
                                    n++;
                                end
                            end
                        end
                    end
                    else
                    begin
                        res[n] = char_result(c);
                        n++;
                    end
                end
            end
            dpd_pkg::PH_HEX_HI, dpd_pkg::PH_HEX_LO:
            begin
                v = hex_nibble(c);
                if (v < 0)
                begin
                    frame_bad = 1'b1;
                    v = 0;
                end
                if (ph == dpd_pkg::PH_HEX_HI)
                begin
                    hi_nib = v[3:0];
                    ph = dpd_pkg::PH_HEX_LO;
                end
                else
                begin
                    rx_sum = {hi_nib, v[3:0]};
                    ph = dpd_pkg::PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
        if (it.in_last)
        begin
            if (held_n < 3)
            begin
                for (int i = 0; i < held_n; i++)
                begin
                    res[n] = char_result(held[i]);
                    n++;
                end
            end
            r = '0;
            r.out_kind = 1'b1;
            r.out_good = (ph == dpd_pkg::PH_DONE) && !frame_bad && (rx_sum == run_sum);
            if (seq_seen)
            begin
                r.out_has_seq = 1'b1;
                r.out_seq_first = held[0];
                r.out_seq_second = held[1];
            end
            res[n] = r;
            n++;
            ph = dpd_pkg::PH_HUNT;
            run_sum = '0;
            hi_nib = '0;
            rx_sum = '0;
            held = '{default: '0};
            held_n = 0;
            seq_seen = 1'b0;
            frame_bad = 1'b0;
            nbytes = 0;
        end
        if (n > 0)
        begin
            res[n - 1].out_last = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            predicted_out.push_back(res[i]);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Request and result sampling at the rising edge.
    always @(posedge clk)
    begin : monitor
        dpd_pkg::out_t w;
        byte_took = rst_n && byte_valid && !byte_stall;
        calm = (tx_bytes.size() < 40);
        if (byte_took)
        begin
            parse_byte(byte_data);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_out.size() == 0)
            begin
                $error("unexpected result: kind %0d char %0d", result_data.out_kind,
                       result_data.out_char);
                err_count++;
            end
            else
            begin
                w = predicted_out.pop_front();
                check_field("out_kind", w.out_kind, result_data.out_kind);
                check_field("out_char", w.out_char, result_data.out_char);
                check_field("out_good", w.out_good, result_data.out_good);
                check_field("out_has_seq", w.out_has_seq, result_data.out_has_seq);
                check_field("out_seq_first", w.out_seq_first, result_data.out_seq_first);
                check_field("out_seq_second", w.out_seq_second, result_data.out_seq_second);
                check_field("out_last", w.out_last, result_data.out_last);
            end
        end
    end

    // Byte sender: holds a stalled request, otherwise idles in bursts or sends the next byte.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
        end
        else if (byte_valid && !byte_took)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            byte_valid <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            gap_left = $urandom_range(0, 8);
            byte_valid <= 1'b0;
        end
        else if (tx_bytes.size() > 0)
        begin
            byte_data <= tx_bytes.pop_front();
            byte_valid <= 1'b1;
        end
        else
        begin
            byte_valid <= 1'b0;
        end
    end

    // Result receiver: one long hold-off to fill the block, then random stall bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles++;
        end
        if (rx_cycles == 60)
        begin
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    function automatic logic [6:0] hex_char(logic [3:0] n, bit lower);
        if (n < 10)
        begin
            return 7'h30 + 7'(n);
        end
        return (lower ? 7'h61 : 7'h41) + 7'(n) - 7'd10;
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom);
        end
        while (b[6:0] == dpd_pkg::CH_END);
        return b;
    endfunction

    // Closes the payload that starts at index first: end mark and two checksum digits.
    task automatic add_check_digits(int first, logic [7:0] skew, bit lower);
        logic [7:0] s;
        s = skew;
        for (int i = first; i < frame_bytes.size(); i++)
        begin
            s = s + {1'b0, frame_bytes[i][6:0]};
        end
        frame_bytes.push_back({1'($urandom_range(0, 1)), dpd_pkg::CH_END});
        frame_bytes.push_back({1'($urandom_range(0, 1)), hex_char(s[7:4], lower)});
        frame_bytes.push_back({1'($urandom_range(0, 1)), hex_char(s[3:0], lower)});
    endtask

    task automatic add_packet(int plen, bit with_seq, flaw_t flaw);
        int         first;
        logic [7:0] b;
        frame_bytes.push_back({1'($urandom_range(0, 1)), dpd_pkg::CH_START});
        first = frame_bytes.size();
        if (with_seq)
        begin
            frame_bytes.push_back(payload_byte());
            frame_bytes.push_back(payload_byte());
            frame_bytes.push_back({1'($urandom_range(0, 1)), dpd_pkg::CH_SEQ});
        end
        for (int i = 0; i < plen; i++)
        begin
            frame_bytes.push_back(payload_byte());
        end
        add_check_digits(first, (flaw == BAD_SUM) ? 8'($urandom_range(1, 255)) : 8'h00,
                         1'($urandom_range(0, 1)));
        if (flaw == BAD_DIGIT)
        begin
            do
            begin
                b = 8'($urandom);
            end
            while (hex_nibble(b[6:0]) >= 0);
            frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 1)] = b;
        end
    endtask

    // Moves the datagram under construction to the send queue, marking its last byte.
    task automatic end_frame();
        dpd_pkg::in_t it;
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            it.in_byte = frame_bytes[i];
            it.in_last = (i == frame_bytes.size() - 1);
            tx_bytes.push_back(it);
        end
        frame_bytes.delete();
    endtask

    initial
    begin : stimulus
        int    sent;
        int    mark;
        int    pick;
        int    keep;
        flaw_t flaw;
        logic [7:0] b;

        // Empty payload after a zero byte; the start character carries the top bit.
        frame_bytes = '{8'h00, 8'hA4, 8'h23, "0", "0"};
        end_frame();
        // A datagram with no start character at all.
        frame_bytes.push_back(8'hFF);
        end_frame();
        // Sequence id, a start character inside the payload, trailing byte ignored.
        frame_bytes = '{"$", "7", "f", ":", "A", "$"};
        add_check_digits(1, 8'h00, 1'b1);
        frame_bytes.push_back(8'h80);
        end_frame();
        // Sequence id on a packet whose checksum is wrong.
        frame_bytes = '{"$", "1", "2", ":"};
        add_check_digits(1, 8'h01, 1'b0);
        end_frame();
        // Short payload flushed, invalid high checksum digit.
        frame_bytes = '{"$", "Q", "#", "g", "5"};
        end_frame();
        // Short payload flushed, checksum cut off after one digit.
        frame_bytes = '{"$", "x", "y", "#", "4"};
        end_frame();

        sent = tx_bytes.size();
        while (sent < 280)
        begin
            mark = tx_bytes.size();
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                repeat ($urandom_range(0, 2))
                begin
                    do
                    begin
                        b = 8'($urandom);
                    end
                    while (b[6:0] == dpd_pkg::CH_START);
                    frame_bytes.push_back(b);
                end
                pick = $urandom_range(0, 9);
                flaw = (pick < 6) ? CLEAN : (pick < 8) ? BAD_SUM : BAD_DIGIT;
                add_packet($urandom_range(0, 12), $urandom_range(0, 9) < 4, flaw);
                if ($urandom_range(0, 99) < 18)
                begin
                    // Cut the datagram short somewhere before its end.
                    keep = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > keep)
                    begin
                        void'(frame_bytes.pop_back());
                    end
                end
                else
                begin
                    repeat ($urandom_range(0, 2))
                    begin
                        frame_bytes.push_back(8'($urandom));
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    frame_bytes.push_back(8'($urandom));
                end
            end
            end_frame();
            sent += tx_bytes.size() - mark;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (tx_bytes.size() > 0 || byte_valid)
        begin
            @(posedge clk);
        end
        while (predicted_out.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (err_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
